FILE: rtl/core/rmf_pkg.sv
package rmf_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LINK_OPEN     = 2'd0,
		REG_DEVICE_ADDR   = 2'd1,
		REG_SETPOINT_REG  = 2'd2,
		REG_PRESENT_REG   = 2'd3
	} cfg_reg_t;

	localparam logic        LINK_OPEN_RST    = 1'b0;
	localparam logic [7:0]  DEVICE_ADDR_RST  = 8'h01;
	localparam logic [15:0] SETPOINT_REG_RST = 16'd300;
	localparam logic [15:0] PRESENT_REG_RST  = 16'h0000;

	localparam logic        OP_READ          = 1'b0;
	localparam logic        OP_WRITE         = 1'b1;
	localparam logic [7:0]  FC_READ_HOLDING  = 8'h03;
	localparam logic [7:0]  FC_WRITE_SINGLE  = 8'h06;
	localparam logic [15:0] READ_COUNT       = 16'h0001;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [2:0]  IDX_CRC_LO = 3'd6;
	localparam logic [2:0]  IDX_LAST   = 3'd7;

	// first six bytes of a request; the CRC is appended by the emitter
	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] fc;
		logic [7:0] reg_hi;
		logic [7:0] reg_lo;
		logic [7:0] data_hi;
		logic [7:0] data_lo;
	} frame_head_t;

	// one byte through the reflected CRC-16/MODBUS
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/rmf_ifs.sv
interface rmf_cmd_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [15:0] setpoint_tenths;

	modport source (output valid, operation, setpoint_tenths, input ready);
	modport sink   (input valid, operation, setpoint_tenths, output ready);
endinterface

interface rmf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;

	modport source (output valid, tx_byte, last_byte, input ready);
	modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

interface rmf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rmf_pkg::CFG_INDEX_W-1:0]  index;
	logic [rmf_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/rmf_front.sv
module rmf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	rmf_cmd_if.sink              cmd,
	rmf_cfg_if.sink              cfg,
	output logic                 push_valid,
	input  logic                 push_ready,
	output rmf_pkg::frame_head_t push_head
);

	logic        link_open_q;
	logic [7:0]  device_addr_q;
	logic [15:0] setpoint_reg_q;
	logic [15:0] present_reg_q;
	logic        keep;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_open_q    <= rmf_pkg::LINK_OPEN_RST;
			device_addr_q  <= rmf_pkg::DEVICE_ADDR_RST;
			setpoint_reg_q <= rmf_pkg::SETPOINT_REG_RST;
			present_reg_q  <= rmf_pkg::PRESENT_REG_RST;
		end else if (cfg.valid) begin
			unique case (rmf_pkg::cfg_reg_t'(cfg.index))
				rmf_pkg::REG_LINK_OPEN:    link_open_q    <= cfg.data[0];
				rmf_pkg::REG_DEVICE_ADDR:  device_addr_q  <= cfg.data[7:0];
				rmf_pkg::REG_SETPOINT_REG: setpoint_reg_q <= cfg.data;
				rmf_pkg::REG_PRESENT_REG:  present_reg_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// closed link or a zero setpoint write: transfer taken, nothing queued
	always_comb begin
		keep = link_open_q &&
			!(cmd.operation == rmf_pkg::OP_WRITE && cmd.setpoint_tenths == 16'sd0);
		push_head.addr = device_addr_q;
		if (cmd.operation == rmf_pkg::OP_WRITE) begin
			push_head.fc      = rmf_pkg::FC_WRITE_SINGLE;
			push_head.reg_hi  = setpoint_reg_q[15:8];
			push_head.reg_lo  = setpoint_reg_q[7:0];
			push_head.data_hi = cmd.setpoint_tenths[15:8];
			push_head.data_lo = cmd.setpoint_tenths[7:0];
		end else begin
			push_head.fc      = rmf_pkg::FC_READ_HOLDING;
			push_head.reg_hi  = present_reg_q[15:8];
			push_head.reg_lo  = present_reg_q[7:0];
			push_head.data_hi = rmf_pkg::READ_COUNT[15:8];
			push_head.data_lo = rmf_pkg::READ_COUNT[7:0];
		end
	end

	assign cmd.ready  = push_ready;
	assign push_valid = cmd.valid && keep;

endmodule

FILE: rtl/core/rmf_queue.sv
module rmf_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push_valid,
	output logic                         push_ready,
	input  rmf_pkg::frame_head_t         push_head,
	output logic                         pop_valid,
	input  logic                         pop_ready,
	output rmf_pkg::frame_head_t         pop_head,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rmf_pkg::frame_head_t entry_q [DEPTH];
	logic [AW-1:0]        wr_ptr_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [CW-1:0]        count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_head   = entry_q[rd_ptr_q];
	assign level      = count_q;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: rtl/core/rmf_back.sv
module rmf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  rmf_pkg::frame_head_t pop_head,
	rmf_rsp_if.source            rsp
);

	rmf_pkg::frame_head_t head_q;
	logic                 busy_q;
	logic [2:0]           idx_q;
	logic [15:0]          crc_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;
	logic                 advance;
	logic [7:0]           cur_byte;

	assign advance   = !out_valid_q || rsp.ready;
	// next frame is taken while the final byte is loaded, or whenever the emitter is idle
	assign pop_ready = advance && (!busy_q || idx_q == rmf_pkg::IDX_LAST);

	always_comb begin
		case (idx_q)
			3'd0:    cur_byte = head_q.addr;
			3'd1:    cur_byte = head_q.fc;
			3'd2:    cur_byte = head_q.reg_hi;
			3'd3:    cur_byte = head_q.reg_lo;
			3'd4:    cur_byte = head_q.data_hi;
			3'd5:    cur_byte = head_q.data_lo;
			3'd6:    cur_byte = crc_q[7:0];
			default: cur_byte = crc_q[15:8];
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			out_byte_q <= cur_byte;
			out_last_q <= idx_q == rmf_pkg::IDX_LAST;
		end
		if (pop_valid && pop_ready)
			head_q <= pop_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			crc_q       <= rmf_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
			if (busy_q && idx_q != rmf_pkg::IDX_LAST) begin
				idx_q <= idx_q + 1'b1;
				// CRC runs alongside the header bytes, ready by byte six
				if (idx_q < rmf_pkg::IDX_CRC_LO)
					crc_q <= rmf_pkg::crc_byte(crc_q, cur_byte);
			end else if (pop_valid) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				crc_q  <= rmf_pkg::CRC_INIT;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.tx_byte   = out_byte_q;
	assign rsp.last_byte = out_last_q;

endmodule

FILE: rtl/core/modbus_rtu_request_framer.sv
// Modbus RTU request framer.
// cmd: one command per transfer (operation, setpoint_tenths). A read gives
//   address, 0x03, present register, count 1; a write gives address, 0x06,
//   setpoint register and the setpoint. Each frame ends in CRC-16/MODBUS,
//   low byte first.
// rsp: eight transfers per frame, one byte each, last_byte on the eighth.
// cfg: register writes (link_open, device_address, setpoint_register,
//   present_register), always ready; to be written only while the block is
//   idle, not enforced by the block. A command is dropped (transfer taken,
//   no bytes) when the link is closed or a write carries a zero setpoint.
// A command passes a queue entry, the header register and the output register
//   before its first byte. Throughput: one byte per cycle while rsp is ready,
//   set by the byte-wide result channel; CRC folds in with each header byte.
// A queue of QUEUE_DEPTH commands sits between the command front and the byte
//   emitter; cmd.ready drops only when it is full.
// A stalled rsp holds its byte in the output register; the emitter and then
//   the queue back up behind it.
// Reset: registers to their defaults (link closed, address 1, setpoint
//   register 300, present register 0); queue and emitter empty.
module modbus_rtu_request_framer #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	rmf_cmd_if.sink    cmd,
	rmf_rsp_if.source  rsp,
	rmf_cfg_if.sink    cfg
);

	logic                             push_valid;
	logic                             push_ready;
	rmf_pkg::frame_head_t             push_head;
	logic                             pop_valid;
	logic                             pop_ready;
	rmf_pkg::frame_head_t             pop_head;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

	rmf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_head  (push_head)
	);

	rmf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_head  (push_head),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_head   (pop_head),
		.level      (level)
	);

	rmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_head  (pop_head),
		.rsp       (rsp)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
		else $error("queue level beyond depth");

	a_push_on_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_ready |-> cmd.valid && cmd.ready)
		else $error("queue push without a command transfer");

	a_empty_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		level == '0 && !(push_valid && push_ready) |=> !pop_valid)
		else $error("queue offers an entry it never received");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int unsigned SETTLE_CYCLES = 40;   // queue of two plus a frame in flight
	localparam int unsigned QUIET_LIMIT   = 3000;
	localparam int unsigned HOLD_CYCLES   = 300;

	typedef struct {
		logic [7:0] tx_byte;
		logic       last_byte;
	} frame_byte_t;

	logic clk;
	logic arst_n;

	rmf_cmd_if cmd_bus ();
	rmf_rsp_if rsp_bus ();
	rmf_cfg_if cfg_bus ();

	modbus_rtu_request_framer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// register copies and pending frame bytes
	logic        link_open_q;
	logic [7:0]  dev_addr_q;
	logic [15:0] sp_reg_q;
	logic [15:0] pv_reg_q;
	frame_byte_t expected_bytes[$];
	frame_byte_t want_byte;

	int unsigned cmd_idle_pct;
	int unsigned rsp_stall_pct;
	int unsigned rsp_hold_left;
	int unsigned errors;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	function automatic logic [15:0] modbus_crc(input logic [7:0] bytes [0:7]);
		logic [15:0] acc;
		acc = 16'hFFFF;
		for (int i = 0; i < 6; i++) begin
			acc = acc ^ {8'h00, bytes[i]};
			for (int b = 0; b < 8; b++) begin
				if (acc[0])
					acc = (acc >> 1) ^ 16'hA001;
				else
					acc = acc >> 1;
			end
		end
		return acc;
	endfunction

	// builds the request frame that a command should produce
	function automatic void predict_request(input logic op, input logic [15:0] sp);
		logic [7:0]  frame [0:7];
		logic [15:0] reg_addr;
		logic [15:0] word;
		logic [15:0] crc;
		if (!link_open_q)
			return;
		if (op == rmf_pkg::OP_WRITE && sp == 16'h0000)
			return;
		reg_addr = (op == rmf_pkg::OP_WRITE) ? sp_reg_q : pv_reg_q;
		word     = (op == rmf_pkg::OP_WRITE) ? sp : rmf_pkg::READ_COUNT;
		frame[0] = dev_addr_q;
		frame[1] = (op == rmf_pkg::OP_WRITE) ? rmf_pkg::FC_WRITE_SINGLE
			: rmf_pkg::FC_READ_HOLDING;
		frame[2] = reg_addr[15:8];
		frame[3] = reg_addr[7:0];
		frame[4] = word[15:8];
		frame[5] = word[7:0];
		frame[6] = 8'h00;
		frame[7] = 8'h00;
		crc = modbus_crc(frame);
		frame[6] = crc[7:0];
		frame[7] = crc[15:8];
		for (int k = 0; k < 8; k++)
			expected_bytes.push_back('{tx_byte: frame[k], last_byte: (k == 7)});
	endfunction

	// called at a rising edge; returns at the edge of the transfer
	task automatic send_command(input logic op, input logic [15:0] sp);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < cmd_idle_pct)
			gap++;
		if (gap != 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid           <= 1'b1;
		cmd_bus.operation       <= op;
		cmd_bus.setpoint_tenths <= sp;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		predict_request(op, sp);
	endtask

	task automatic write_register(input rmf_pkg::cfg_reg_t idx, input logic [15:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		case (idx)
			rmf_pkg::REG_LINK_OPEN:    link_open_q = value[0];
			rmf_pkg::REG_DEVICE_ADDR:  dev_addr_q  = value[7:0];
			rmf_pkg::REG_SETPOINT_REG: sp_reg_q    = value;
			rmf_pkg::REG_PRESENT_REG:  pv_reg_q    = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drop valid, drain every frame, then idle so that a stray byte is still caught
	task automatic settle;
		cmd_bus.valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] random_setpoint;
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'h8000;
			2:       return 16'h7FFF;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_link_closed;
		send_command(rmf_pkg::OP_READ, 16'h0000);
		send_command(rmf_pkg::OP_WRITE, 16'h1234);
		settle();
	endtask

	task automatic test_reset_defaults;
		write_register(rmf_pkg::REG_LINK_OPEN, 16'h0001);
		send_command(rmf_pkg::OP_READ, 16'hFFFF);
		send_command(rmf_pkg::OP_WRITE, 16'h0001);
		settle();
	endtask

	task automatic test_field_extremes;
		write_register(rmf_pkg::REG_DEVICE_ADDR, 16'h00FF);
		write_register(rmf_pkg::REG_SETPOINT_REG, 16'hFFFF);
		write_register(rmf_pkg::REG_PRESENT_REG, 16'hFFFF);
		send_command(rmf_pkg::OP_WRITE, 16'h7FFF);
		send_command(rmf_pkg::OP_WRITE, 16'h8000);
		send_command(rmf_pkg::OP_WRITE, 16'hFFFF);
		send_command(rmf_pkg::OP_WRITE, 16'h0000);  // zero setpoint, dropped
		send_command(rmf_pkg::OP_READ, 16'h0000);   // read ignores the setpoint
		send_command(rmf_pkg::OP_READ, 16'h8000);
		settle();
		// upper bits beyond the register are discarded
		write_register(rmf_pkg::REG_DEVICE_ADDR, 16'hFF00);
		write_register(rmf_pkg::REG_SETPOINT_REG, 16'h0000);
		write_register(rmf_pkg::REG_PRESENT_REG, 16'h0000);
		send_command(rmf_pkg::OP_READ, 16'h5555);
		send_command(rmf_pkg::OP_WRITE, 16'h5555);
		send_command(rmf_pkg::OP_WRITE, 16'hAAAA);
		settle();
		write_register(rmf_pkg::REG_LINK_OPEN, 16'hFFFE);
		send_command(rmf_pkg::OP_READ, 16'h0001);
		send_command(rmf_pkg::OP_WRITE, 16'h0001);
		settle();
		write_register(rmf_pkg::REG_LINK_OPEN, 16'h0001);
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
		input int unsigned count);
		write_register(rmf_pkg::REG_LINK_OPEN, {15'($urandom), 1'b1});
		write_register(rmf_pkg::REG_DEVICE_ADDR, 16'($urandom));
		write_register(rmf_pkg::REG_SETPOINT_REG, 16'($urandom));
		write_register(rmf_pkg::REG_PRESENT_REG, 16'($urandom));
		cmd_idle_pct  = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (count)
			send_command(1'($urandom), random_setpoint());
		settle();
	endtask

	task automatic test_back_pressure;
		cmd_idle_pct  = 0;
		rsp_stall_pct = 0;
		rsp_hold_left = HOLD_CYCLES;
		repeat (12)
			send_command(1'($urandom), random_setpoint());
		settle();
	endtask

	// result side ready; a hold-off overrides the random stalls
	always @(posedge clk) begin
		if (rsp_hold_left != 0) begin
			rsp_bus.ready <= 1'b0;
			rsp_hold_left = rsp_hold_left - 1;
		end else begin
			rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("byte %02h with no frame pending", rsp_bus.tx_byte));
			end else begin
				want_byte = expected_bytes.pop_front();
				if (rsp_bus.tx_byte !== want_byte.tx_byte)
					report_mismatch($sformatf("tx_byte %02h, want %02h",
						rsp_bus.tx_byte, want_byte.tx_byte));
				if (rsp_bus.last_byte !== want_byte.last_byte)
					report_mismatch($sformatf("last_byte %b, want %b",
						rsp_bus.last_byte, want_byte.last_byte));
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
				(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
				(cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] no transfer for %0d cycles", $realtime, QUIET_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n                  = 1'b0;
		cmd_bus.valid           = 1'b0;
		cmd_bus.operation       = 1'b0;
		cmd_bus.setpoint_tenths = 16'h0000;
		cfg_bus.valid           = 1'b0;
		cfg_bus.index           = rmf_pkg::REG_LINK_OPEN;
		cfg_bus.data            = 16'h0000;
		rsp_bus.ready           = 1'b0;
		link_open_q             = rmf_pkg::LINK_OPEN_RST;
		dev_addr_q              = rmf_pkg::DEVICE_ADDR_RST;
		sp_reg_q                = rmf_pkg::SETPOINT_REG_RST;
		pv_reg_q                = rmf_pkg::PRESENT_REG_RST;
		cmd_idle_pct            = 0;
		rsp_stall_pct           = 0;
		rsp_hold_left           = 0;
		errors                  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_link_closed();
		test_reset_defaults();
		test_field_extremes();
		test_random_traffic(0, 0, 24);
		test_random_traffic(83, 0, 24);
		test_random_traffic(0, 83, 24);
		test_random_traffic(13, 13, 24);
		test_back_pressure();

		if (expected_bytes.size() != 0)
			report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
